[rtl/ssgc_pkg.sv]
// ----------------------------------------------------------------------------
// ssgc_pkg
// Shared widths, register codes and request/result types of the section
// gray mapper with curve overlay.
// ----------------------------------------------------------------------------
package ssgc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ROW_BITS    = 12;
  localparam int CURVE_BITS  = 16;
  localparam int PEN_BITS    = 5;
  localparam int COUNT_BITS  = ROW_BITS + 1;
  localparam int COLOR_BITS  = 8;

  localparam int GRAY_TOP  = 255;
  localparam int GRAY_STEP = 254;

  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int NUM_W   = SAMPLE_BITS + 10;
  localparam int DEN_W   = SAMPLE_BITS + 1;
  localparam int QUO_W   = COLOR_BITS;
  localparam int REM_W   = DEN_W + QUO_W;
  localparam int FULL_W  = NUM_W + 1;
  localparam int CLAMP_W = ((CURVE_BITS > COUNT_BITS) ? CURVE_BITS : COUNT_BITS) + 1;
  localparam int POS_W   = COUNT_BITS + 2;

  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;

  localparam int WIN_LOW_INIT   = -32768;
  localparam int WIN_HIGH_INIT  = 32767;
  localparam int ROW_COUNT_INIT = 4096;

  localparam logic [SAMPLE_BITS-1:0] WIN_LOW_RST   = SAMPLE_BITS'(WIN_LOW_INIT);
  localparam logic [SAMPLE_BITS-1:0] WIN_HIGH_RST  = SAMPLE_BITS'(WIN_HIGH_INIT);
  localparam logic [COLOR_BITS-1:0]  RED_RST       = COLOR_BITS'(0);
  localparam logic [COLOR_BITS-1:0]  GREEN_RST     = COLOR_BITS'(255);
  localparam logic [COLOR_BITS-1:0]  BLUE_RST      = COLOR_BITS'(0);
  localparam logic [PEN_BITS-1:0]    PEN_RST       = PEN_BITS'(2);
  localparam logic [COUNT_BITS-1:0]  ROW_COUNT_RST = COUNT_BITS'(ROW_COUNT_INIT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_LOW   = 3'd0,
    CFG_WIN_HIGH  = 3'd1,
    CFG_RED       = 3'd2,
    CFG_GREEN     = 3'd3,
    CFG_BLUE      = 3'd4,
    CFG_PEN       = 3'd5,
    CFG_ROW_COUNT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [ROW_BITS-1:0]    pixel_row;
    logic signed [CURVE_BITS-1:0]  curve_row;
  } in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } out_t;

  typedef struct packed {
    logic vld;
    logic cov;
  } tag_t;

endpackage

[rtl/ssgc_div.sv]
// ----------------------------------------------------------------------------
// ssgc_div
// Pipelined restoring divider for the gray level: two quotient bits per
// stage, one request per cycle, tag bits carried alongside.
// ----------------------------------------------------------------------------
module ssgc_div import ssgc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tag_t             in_tag,
  input  logic [REM_W-1:0] in_rem,
  input  logic [DEN_W-1:0] in_den,
  output tag_t             out_tag,
  output logic [QUO_W-1:0] out_quo
);

  tag_t             tag_r [DIV_STAGES];
  logic [REM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    tag_t             tag_i;
    logic [REM_W-1:0] rem_i;
    logic [REM_W-1:0] rem_nxt;
    logic [DEN_W-1:0] den_i;
    logic [QUO_W-1:0] quo_i;
    logic [QUO_W-1:0] quo_nxt;

    if (g == 0) begin : g_first
      assign tag_i = in_tag;
      assign rem_i = in_rem;
      assign den_i = in_den;
      assign quo_i = '0;
    end else begin : g_next
      assign tag_i = tag_r[g-1];
      assign rem_i = rem_r[g-1];
      assign den_i = den_r[g-1];
      assign quo_i = quo_r[g-1];
    end

    always_comb begin
      logic [REM_W-1:0] trial;
      rem_nxt = rem_i;
      quo_nxt = quo_i;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        trial = REM_W'(den_i) << (QUO_W - 1 - g * BITS_PER_STAGE - j);
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          quo_nxt = quo_nxt | (QUO_W'(1) << (QUO_W - 1 - g * BITS_PER_STAGE - j));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[g] <= '0;
      end else begin
        tag_r[g] <= tag_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= rem_nxt;
      den_r[g] <= den_i;
      quo_r[g] <= quo_nxt;
    end
  end

  assign out_tag = tag_r[DIV_STAGES-1];
  assign out_quo = quo_r[DIV_STAGES-1];

  a_vld_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_tag.vld |-> $past(in_tag.vld, DIV_STAGES))
    else $error("divider output without matching input");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tag.vld |-> (rem_r[DIV_STAGES-1] < REM_W'(den_r[DIV_STAGES-1])))
    else $error("divider remainder not below divisor");

  a_cov_carry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tag.vld |-> (out_tag.cov == $past(in_tag.cov, DIV_STAGES)))
    else $error("divider tag corrupted");

endmodule

[rtl/seismic_section_gray_with_curve.sv]
// ----------------------------------------------------------------------------
// seismic_section_gray_with_curve
// Throughput: one request per cycle while busy is low. Each accepted request
// passes the eight-register pipeline (three arithmetic stages, four divider
// stages, output register) and then shows its pixel on out_data with
// out_valid high. Reset: synchronous; busy is high during reset and clears
// at the first clock edge after it. Configuration, valid and tag registers
// return to their reset values; the result side never stalls.
// ----------------------------------------------------------------------------
module seismic_section_gray_with_curve import ssgc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [SAMPLE_BITS-1:0] win_low_r;
  logic signed [SAMPLE_BITS-1:0] win_high_r;
  logic [COLOR_BITS-1:0]         red_r;
  logic [COLOR_BITS-1:0]         green_r;
  logic [COLOR_BITS-1:0]         blue_r;
  logic [PEN_BITS-1:0]           pen_r;
  logic [COUNT_BITS-1:0]         rows_r;
  logic                          busy_r;

  logic accept;

  // stage a
  logic signed [DIFF_W-1:0]     range_a;
  logic signed [DIFF_W-1:0]     diff_a;
  logic [SAMPLE_BITS-1:0]       d_a;
  logic signed [CLAMP_W-1:0]    crv_a;
  logic signed [CLAMP_W-1:0]    lim_a;
  logic signed [CLAMP_W-1:0]    clamp_a;
  logic                         rowok_a;

  logic                         a_vld_r;
  logic signed [DIFF_W-1:0]     a_diff_r;
  logic [SAMPLE_BITS-1:0]       a_d_r;
  logic [ROW_BITS-1:0]          a_row_r;
  logic [COUNT_BITS-1:0]        a_crv_r;
  logic                         a_rowok_r;

  // stage b
  logic signed [NUM_W-1:0]      num_b;
  logic signed [POS_W-1:0]      start_b;
  logic signed [POS_W-1:0]      row_b;
  logic                         cov_b;

  tag_t                         b_tag_r;
  logic signed [NUM_W-1:0]      b_num_r;
  logic [SAMPLE_BITS-1:0]       b_d_r;

  // stage c
  logic [DEN_W-1:0]             den_c;
  logic [FULL_W-1:0]            full_c;
  logic [REM_W-1:0]             cap_c;
  logic [REM_W-1:0]             rem_c;

  tag_t                         c_tag_r;
  logic [REM_W-1:0]             c_rem_r;
  logic [DEN_W-1:0]             c_den_r;

  tag_t                         div_tag;
  logic [QUO_W-1:0]             div_quo;

  logic                         out_valid_r;
  logic                         out_cov_r;
  out_t                         out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= WIN_LOW_RST;
      win_high_r <= WIN_HIGH_RST;
      red_r      <= RED_RST;
      green_r    <= GREEN_RST;
      blue_r     <= BLUE_RST;
      pen_r      <= PEN_RST;
      rows_r     <= ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIN_LOW:   win_low_r  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_WIN_HIGH:  win_high_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_RED:       red_r      <= cfg_data[COLOR_BITS-1:0];
        CFG_GREEN:     green_r    <= cfg_data[COLOR_BITS-1:0];
        CFG_BLUE:      blue_r     <= cfg_data[COLOR_BITS-1:0];
        CFG_PEN:       pen_r      <= cfg_data[PEN_BITS-1:0];
        CFG_ROW_COUNT: rows_r     <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign accept    = start && !busy_r;

  // stage a: window offsets, curve clamp
  always_comb begin
    range_a = DIFF_W'(win_high_r) - DIFF_W'(win_low_r);
    diff_a  = DIFF_W'(in_data.sample) - DIFF_W'(win_low_r);
    d_a     = (range_a > 0) ? range_a[SAMPLE_BITS-1:0] : SAMPLE_BITS'(1);
    crv_a   = CLAMP_W'(in_data.curve_row);
    lim_a   = signed'(CLAMP_W'(rows_r)) - CLAMP_W'(1);
    if (crv_a < 0) begin
      clamp_a = '0;
    end else if (crv_a > lim_a) begin
      clamp_a = lim_a;
    end else begin
      clamp_a = crv_a;
    end
    rowok_a = (rows_r != '0) && (COUNT_BITS'(in_data.pixel_row) < rows_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_diff_r  <= diff_a;
    a_d_r     <= d_a;
    a_row_r   <= in_data.pixel_row;
    a_crv_r   <= clamp_a[COUNT_BITS-1:0];
    a_rowok_r <= rowok_a;
  end

  // stage b: numerator, pen cover
  always_comb begin
    num_b   = signed'(NUM_W'(a_d_r)) * NUM_W'(GRAY_TOP)
            - NUM_W'(a_diff_r) * NUM_W'(GRAY_STEP);
    start_b = signed'(POS_W'(a_crv_r)) - signed'(POS_W'(pen_r >> 1));
    row_b   = signed'(POS_W'(a_row_r));
    cov_b   = a_rowok_r && (start_b <= row_b)
            && (row_b < start_b + signed'(POS_W'(pen_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r <= '0;
    end else begin
      b_tag_r <= '{vld: a_vld_r, cov: cov_b};
    end
  end

  always_ff @(posedge clk) begin
    b_num_r <= num_b;
    b_d_r   <= a_d_r;
  end

  // stage c: rounding offset and saturation at full scale
  always_comb begin
    den_c  = {b_d_r, 1'b0};
    full_c = (b_num_r > 0) ? ((FULL_W'(unsigned'(b_num_r)) << 1) + FULL_W'(b_d_r))
                           : '0;
    cap_c  = {den_c, {QUO_W{1'b0}}} - REM_W'(1);
    rem_c  = (full_c > FULL_W'(cap_c)) ? cap_c : full_c[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_tag_r <= '0;
    end else begin
      c_tag_r <= b_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    c_rem_r <= rem_c;
    c_den_r <= den_c;
  end

  ssgc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (c_tag_r),
    .in_rem  (c_rem_r),
    .in_den  (c_den_r),
    .out_tag (div_tag),
    .out_quo (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_cov_r   <= 1'b0;
    end else begin
      out_valid_r <= div_tag.vld;
      out_cov_r   <= div_tag.cov;
    end
  end

  always_ff @(posedge clk) begin
    if (div_tag.cov) begin
      out_data_r <= '{red: red_r, green: green_r, blue: blue_r};
    end else begin
      out_data_r <= '{red: div_quo, green: div_quo, blue: div_quo};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 8))
    else $error("result without request");

  a_busy_reset: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $past(!rst_n))
    else $error("busy outside reset recovery");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(a_vld_r && !a_rowok_r, 7)) |-> !out_cov_r)
    else $error("curve drawn outside section rows");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the section gray mapper with curve overlay. Pixel
// requests go in through start/busy and pixels come out on the out_valid
// strobe. Each accepted request is mapped by a local pixel model that keeps its
// own register copy. Every strobed pixel is checked against the oldest pending
// expectation. The run goes through a directed set under reset settings, then
// random phases. Each phase loads new window, colour, pen and row settings
// while the pipeline is empty. Sender idling varies from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import ssgc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 8;
  localparam int MAX_PRINTS   = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  class pixel_scoreboard;
    logic signed [SAMPLE_BITS-1:0] win_low;
    logic signed [SAMPLE_BITS-1:0] win_high;
    logic [COLOR_BITS-1:0]         pen_red;
    logic [COLOR_BITS-1:0]         pen_green;
    logic [COLOR_BITS-1:0]         pen_blue;
    logic [PEN_BITS-1:0]           pen_rows;
    logic [COUNT_BITS-1:0]         row_total;
    out_t                          pixel_q[$];
    int                            mismatches;

    function new();
      win_low    = WIN_LOW_RST;
      win_high   = WIN_HIGH_RST;
      pen_red    = RED_RST;
      pen_green  = GREEN_RST;
      pen_blue   = BLUE_RST;
      pen_rows   = PEN_RST;
      row_total  = ROW_COUNT_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_WIN_LOW:   win_low   = d[SAMPLE_BITS-1:0];
        CFG_WIN_HIGH:  win_high  = d[SAMPLE_BITS-1:0];
        CFG_RED:       pen_red   = d[COLOR_BITS-1:0];
        CFG_GREEN:     pen_green = d[COLOR_BITS-1:0];
        CFG_BLUE:      pen_blue  = d[COLOR_BITS-1:0];
        CFG_PEN:       pen_rows  = d[PEN_BITS-1:0];
        CFG_ROW_COUNT: row_total = d[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function out_t map_pixel(in_t px);
      longint s, lo, hi, d, num, q, row, c, n, pen, pen_start;
      bit     covered;
      out_t   pix;
      s   = $signed(px.sample);
      lo  = win_low;
      hi  = win_high;
      row = px.pixel_row;
      c   = $signed(px.curve_row);
      n   = row_total;
      pen = pen_rows;
      covered = 1'b0;
      if (n > 0 && row < n) begin
        if (c < 0) c = 0;
        else if (c > n - 1) c = n - 1;
        pen_start = c - pen / 2;
        covered = (pen_start <= row) && (row < pen_start + pen);
      end
      if (covered) begin
        pix.red   = pen_red;
        pix.green = pen_green;
        pix.blue  = pen_blue;
      end else begin
        d = hi - lo;
        if (d < 1) d = 1;
        num = GRAY_TOP * d - GRAY_STEP * (s - lo);
        if (num <= 0) begin
          q = 0;
        end else begin
          q = (2 * num + d) / (2 * d);
          if (q > GRAY_TOP) q = GRAY_TOP;
        end
        pix.red   = COLOR_BITS'(q);
        pix.green = COLOR_BITS'(q);
        pix.blue  = COLOR_BITS'(q);
      end
      return pix;
    endfunction

    function void note_request(in_t px);
      pixel_q.push_back(map_pixel(px));
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTS) $display("[%0t] error: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_pixel(out_t got);
      out_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel %h with no request pending", got));
      end else begin
        want = pixel_q.pop_front();
        if (got.red !== want.red)
          report($sformatf("red got %0d want %0d", got.red, want.red));
        if (got.green !== want.green)
          report($sformatf("green got %0d want %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report($sformatf("blue got %0d want %0d", got.blue, want.blue));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard sb = new();
  int              cycles = 0;
  int              idle_pct[3] = '{0, 66, 24};

  seismic_section_gray_with_curve uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_pixel(out_data);
  end

  task automatic send_pixel(in_t px, int idle);
    if ($urandom_range(1, 100) <= idle) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
    sb.note_request(px);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
  endtask

  task automatic load_settings(longint lo, longint hi, int r, int g, int b, int pen,
                               int rows);
    write_reg(CFG_WIN_LOW, CFG_DATA_W'(lo));
    write_reg(CFG_WIN_HIGH, CFG_DATA_W'(hi));
    write_reg(CFG_RED, CFG_DATA_W'(r));
    write_reg(CFG_GREEN, CFG_DATA_W'(g));
    write_reg(CFG_BLUE, CFG_DATA_W'(b));
    write_reg(CFG_PEN, CFG_DATA_W'(pen));
    write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // samples around the window edges half the time and rows mostly around the pen
  function automatic in_t rand_pixel();
    in_t    px;
    longint lo, hi, span, rows, c;
    lo   = sb.win_low;
    hi   = sb.win_high;
    span = hi - lo;
    rows = sb.row_total;
    case ($urandom_range(0, 3))
      0: px.sample = SAMPLE_BITS'($urandom);
      1: px.sample = SAMPLE_BITS'(lo + longint'($urandom_range(0, 8)) - 4);
      2: px.sample = SAMPLE_BITS'(hi + longint'($urandom_range(0, 8)) - 4);
      default: begin
        if (span > 0) px.sample = SAMPLE_BITS'(lo + longint'($urandom_range(0, span)));
        else px.sample = SAMPLE_BITS'($urandom);
      end
    endcase
    case ($urandom_range(0, 3))
      0: px.curve_row = CURVE_BITS'($urandom);
      1: px.curve_row = CURVE_BITS'(longint'($urandom_range(0, 8)) - 4);
      2: px.curve_row = CURVE_BITS'(rows + longint'($urandom_range(0, 8)) - 4);
      default: px.curve_row = CURVE_BITS'($urandom_range(0, rows));
    endcase
    c = $signed(px.curve_row);
    if (c < 0) c = 0;
    else if (rows > 0 && c > rows - 1) c = rows - 1;
    case ($urandom_range(0, 4))
      0: px.pixel_row = ROW_BITS'($urandom);
      1: px.pixel_row = ROW_BITS'(rows + longint'($urandom_range(0, 8)) - 4);
      default: px.pixel_row = ROW_BITS'(c + longint'($urandom_range(0, 40)) - 20);
    endcase
    return px;
  endfunction

  initial begin
    in_t dir_q[$];
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full window, green pen two rows wide, 4096 rows
    dir_q.push_back(in_t'{16'sh8000, 12'd0, 16'sd100});
    dir_q.push_back(in_t'{16'sh7fff, 12'd0, 16'sd100});
    dir_q.push_back(in_t'{16'sh0000, 12'd2048, 16'sd100});
    dir_q.push_back(in_t'{16'shffff, 12'd1, 16'sd100});
    dir_q.push_back(in_t'{16'sh0001, 12'd100, 16'sd100});
    dir_q.push_back(in_t'{16'sh0000, 12'd99, 16'sd100});
    dir_q.push_back(in_t'{16'sh0000, 12'd101, 16'sd100});
    dir_q.push_back(in_t'{16'sh0000, 12'd98, 16'sd100});
    dir_q.push_back(in_t'{16'shffff, 12'd0, 16'sh8000});
    dir_q.push_back(in_t'{16'shffff, 12'd1, 16'sh8000});
    dir_q.push_back(in_t'{16'sh0001, 12'd4095, 16'sh7fff});
    dir_q.push_back(in_t'{16'sh0001, 12'd4094, 16'sh7fff});
    dir_q.push_back(in_t'{16'sh0001, 12'd4093, 16'sh7fff});
    dir_q.push_back(in_t'{16'sh3039, 12'd0, 16'sd0});
    dir_q.push_back(in_t'{16'shcfc7, 12'd1, 16'sd0});
    dir_q.push_back(in_t'{16'sh5555, 12'd4095, 16'sd4096});
    dir_q.push_back(in_t'{16'shaaaa, 12'd4095, -16'sd5});
    dir_q.push_back(in_t'{16'sh0000, 12'hfff, 16'shffff});
    foreach (dir_q[i]) send_pixel(dir_q[i], 0);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: load_settings(-1000, 1000, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), 1, 4096);
        1: load_settings(100, -100, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), 0, 100);
        2: load_settings(5, 5, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), 16, 1);
        3: load_settings(-32768, 32767, 255, 255, 255, 31, 0);
        4: load_settings(0, 1, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(17, 31),
                         $urandom_range(2, 64));
        5: load_settings(32767, -32768, 0, 0, 0, 1, 4096);
        default: load_settings(longint'($signed(16'($urandom))),
                               longint'($signed(16'($urandom))),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 31),
                               $urandom_range(0, 4096));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(rand_pixel(), idle_pct[phase % 3]);
      drain();
    end

    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
